[rtl/rfa8_pkg.sv]
// Shared types and constants for the 8-bit register file ALU.
// Holds the transfer payload structs, the mode codes and the ALU operand bundle.
// Depends on nothing.
package rfa8_pkg;

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_FADD = 3'd1;
  localparam logic [2:0] MODE_OR   = 3'd2;
  localparam logic [2:0] MODE_AND  = 3'd3;
  localparam logic [2:0] MODE_XOR  = 3'd4;
  localparam logic [2:0] MODE_ROR  = 3'd5;
  localparam logic [2:0] MODE_LOAD = 3'd6;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] dest_reg;
    logic [3:0] src_a_reg;
    logic [3:0] third_operand;
    logic [7:0] load_value;
  } instr_t;

  typedef struct packed {
    logic [3:0] written_reg;
    logic [7:0] written_value;
  } res_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] a;
    logic [7:0] b;
    logic [2:0] amt;
    logic [7:0] load_value;
  } alu_op_t;

endpackage

[rtl/rfa8_regmem.sv]
// Register file storage: one write port, two registered read ports.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on nothing.
module rfa8_regmem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] ra_addr,
  input  logic [AW-1:0] rb_addr,
  output logic [7:0]    ra_data,
  output logic [7:0]    rb_data,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [7:0]       ra_q;
  logic [7:0]       rb_q;
  logic             va_q;
  logic             vb_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      ra_q <= mem[ra_addr];
      rb_q <= mem[rb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (rd_en) begin
        va_q <= vld[ra_addr];
        vb_q <= vld[rb_addr];
      end
    end
  end

  assign ra_data = va_q ? ra_q : 8'h00;
  assign rb_data = vb_q ? rb_q : 8'h00;

endmodule

[rtl/rfa8_alu.sv]
// Byte ALU: integer add, small float add, bitwise ops, rotate right, load and pass-through of b.
// Uses the operand bundle and mode codes from rfa8_pkg.
module rfa8_alu (
  input  rfa8_pkg::alu_op_t op,
  output logic [7:0]        result
);

  logic       sa, sb, sr;
  logic [2:0] ea, eb, er;
  logic [3:0] ma, mb, mr;
  logic [4:0] msum;
  logic [7:0] fres;
  logic [15:0] rot;

  always_comb begin
    sa = op.a[7];
    sb = op.b[7];
    ea = op.a[6:4];
    eb = op.b[6:4];
    ma = op.a[3:0];
    mb = op.b[3:0];
    if (ea < eb) begin
      ma = ma >> (eb - ea);
      er = eb;
    end else begin
      mb = mb >> (ea - eb);
      er = ea;
    end
    msum = {1'b0, ma} + {1'b0, mb};
    if (sa == sb) begin
      sr = sa;
      if (msum[4]) begin
        mr = msum[4:1];
        er = er + 3'd1;
      end else begin
        mr = msum[3:0];
      end
    end else if (ma >= mb) begin
      sr = sa;
      mr = ma - mb;
    end else begin
      sr = sb;
      mr = mb - ma;
    end
    fres = {sr, er, mr};
  end

  assign rot = {op.b, op.b} >> op.amt;

  always_comb begin
    unique case (op.mode)
      rfa8_pkg::MODE_ADD:  result = op.a + op.b;
      rfa8_pkg::MODE_FADD: result = fres;
      rfa8_pkg::MODE_OR:   result = op.a | op.b;
      rfa8_pkg::MODE_AND:  result = op.a & op.b;
      rfa8_pkg::MODE_XOR:  result = op.a ^ op.b;
      rfa8_pkg::MODE_ROR:  result = rot[7:0];
      rfa8_pkg::MODE_LOAD: result = op.load_value;
      default:             result = op.b;
    endcase
  end

endmodule

[rtl/register_file_alu_8bit_core.sv]
// Top level of the 8-bit register file ALU: read stage, execute/write-back stage, result register.
// Depends on rfa8_pkg, rfa8_regmem and rfa8_alu.
//
//   channel | valid       | stall       | payload
//   instr   | instr_valid | instr_stall | instr (rfa8_pkg::instr_t), into the block
//   res     | res_valid   | res_stall   | res   (rfa8_pkg::res_t), out of the block
//
// One instruction per cycle unless res stalls; each result is registered as it leaves execute.
// The register file is read at the transfer edge and written as the item leaves execute;
// a result written at the same edge as the read is forwarded from the result register.
// Reset makes all registers read as zero through per-entry valid bits; no clearing pass.
// A stalled result holds one further item in execute, after which instr_stall rises.
module register_file_alu_8bit_core #(
  parameter int NUM_REGS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             instr_valid,
  output logic             instr_stall,
  input  rfa8_pkg::instr_t instr,
  output logic             res_valid,
  input  logic             res_stall,
  output rfa8_pkg::res_t   res
);

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic             instr_accept;
  logic             s1_valid;
  rfa8_pkg::instr_t s1_item;
  logic             s1_a_ok;
  logic             s1_b_ok;
  logic             s1_fwd_a;
  logic             s1_fwd_b;
  logic             s1_advance;
  logic             s1_wr;
  logic             b_uses_dest;
  logic [3:0]       b_idx;
  logic             fwd_a_next;
  logic             fwd_b_next;
  logic [7:0]       ra_data;
  logic [7:0]       rb_data;
  rfa8_pkg::alu_op_t alu_op;
  logic [7:0]       alu_res;

  assign instr_accept = instr_valid && !instr_stall;
  assign s1_advance   = s1_valid && (!res_valid || !res_stall);
  assign instr_stall  = s1_valid && !s1_advance;

  assign b_uses_dest = (instr.mode == rfa8_pkg::MODE_ROR) || (instr.mode > rfa8_pkg::MODE_LOAD);
  assign b_idx       = b_uses_dest ? instr.dest_reg : instr.third_operand;

  assign s1_wr = (s1_item.mode <= rfa8_pkg::MODE_LOAD) && (int'(s1_item.dest_reg) < NUM_REGS);

  assign fwd_a_next = s1_advance && s1_wr && (s1_item.dest_reg == instr.src_a_reg);
  assign fwd_b_next = s1_advance && s1_wr && (s1_item.dest_reg == b_idx);

  rfa8_regmem #(
    .DEPTH(NUM_REGS),
    .AW   (AW)
  ) u_regmem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (instr_accept),
    .ra_addr(AW'(instr.src_a_reg)),
    .rb_addr(AW'(b_idx)),
    .ra_data(ra_data),
    .rb_data(rb_data),
    .we     (s1_advance && s1_wr),
    .waddr  (AW'(s1_item.dest_reg)),
    .wdata  (alu_res)
  );

  always_comb begin
    alu_op.mode       = s1_item.mode;
    alu_op.a          = s1_fwd_a ? res.written_value : (s1_a_ok ? ra_data : 8'h00);
    alu_op.b          = s1_fwd_b ? res.written_value : (s1_b_ok ? rb_data : 8'h00);
    alu_op.amt        = s1_item.third_operand[2:0];
    alu_op.load_value = s1_item.load_value;
  end

  rfa8_alu u_alu (
    .op    (alu_op),
    .result(alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd_a <= 1'b0;
      s1_fwd_b <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (instr_accept) begin
        s1_valid <= 1'b1;
        s1_fwd_a <= fwd_a_next;
        s1_fwd_b <= fwd_b_next;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
        s1_fwd_a <= 1'b0;
        s1_fwd_b <= 1'b0;
      end
      if (s1_advance) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (instr_accept) begin
      s1_item <= instr;
      s1_a_ok <= int'(instr.src_a_reg) < NUM_REGS;
      s1_b_ok <= int'(b_idx) < NUM_REGS;
    end
    if (s1_advance) begin
      res.written_reg   <= s1_item.dest_reg;
      res.written_value <= alu_res;
    end
  end

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (rst)
    (s1_fwd_a || s1_fwd_b) |-> s1_valid)
    else $error("forward flag set with execute stage empty");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    instr_accept |=> s1_valid)
    else $error("transfer in did not reach execute stage");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_item)))
    else $error("held execute item changed");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_advance))
    else $error("result appeared without an item leaving execute");

endmodule
